// ===== sv/irtx_pkg.sv =====
// Shared types, constants and a helper function for the IR remote frame transmitter.
package irtx_pkg;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam logic [2:0] REG_CARRIER_HALF = 3'd0;
    localparam logic [2:0] REG_CYCLES_SLOT  = 3'd1;
    localparam logic [2:0] REG_GAP_TICKS    = 3'd2;
    localparam logic [2:0] REG_DEV_ADDR     = 3'd3;
    localparam logic [2:0] REG_RED_CODE     = 3'd4;
    localparam logic [2:0] REG_GREEN_CODE   = 3'd5;

    localparam logic [7:0]  RST_CARRIER_HALF = 8'd13;
    localparam logic [9:0]  RST_CYCLES_SLOT  = 10'd157;
    localparam logic [23:0] RST_GAP_TICKS    = 24'd255000;
    localparam logic [7:0]  RST_DEV_ADDR     = 8'd0;
    localparam logic [7:0]  RST_RED_CODE     = 8'd1;
    localparam logic [7:0]  RST_GREEN_CODE   = 8'd2;

    localparam logic [7:0]  OFF_CODE = 8'd0;

    localparam int FRAME_SLOTS      = 57;
    localparam int WAKE_SPACE_SLOT  = 1;
    localparam int LEAD_SPACE_FIRST = 5;
    localparam int LEAD_SPACE_LAST  = 7;
    localparam int FIRST_DATA_SLOT  = 8;
    localparam int DATA_BITS        = 16;
    localparam int SLOTS_PER_BIT    = 3;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_FRAME = 2'd1,
        PH_GAP   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        SLOT_MARK  = 2'd0,
        SLOT_SPACE = 2'd1,
        SLOT_BIT   = 2'd2,
        SLOT_TRAIL = 2'd3
    } slot_kind_t;

    typedef struct packed {
        logic [7:0]  carrier_half_ticks;
        logic [9:0]  cycles_per_slot;
        logic [23:0] gap_ticks;
        logic [7:0]  addr_byte;
        logic [7:0]  red_code;
        logic [7:0]  green_code;
    } cfg_t;

    typedef struct packed {
        logic ir_led;
        logic busy_res;
    } result_t;

    // Classifies a frame slot. The trailing space of each data bit is where
    // the payload shifts to the next bit.
    function automatic slot_kind_t slot_kind(input logic [5:0] s);
        slot_kind_t k;
        k = SLOT_MARK;
        if (s == 6'(WAKE_SPACE_SLOT)
            || (s >= 6'(LEAD_SPACE_FIRST) && s <= 6'(LEAD_SPACE_LAST)))
        begin
            k = SLOT_SPACE;
        end
        for (int i = 0; i < DATA_BITS; i++)
        begin
            if (s == 6'(FIRST_DATA_SLOT + SLOTS_PER_BIT * i + 1))
            begin
                k = SLOT_BIT;
            end
            else if (s == 6'(FIRST_DATA_SLOT + SLOTS_PER_BIT * i + 2))
            begin
                k = SLOT_TRAIL;
            end
        end
        return k;
    endfunction

endpackage

// ===== sv/irtx_tick_if.sv =====
// Input channel carrying one tick with the three button levels.
interface irtx_tick_if;
    logic valid;
    logic ready;
    logic off_button_n;
    logic red_button_n;
    logic green_button_n;

    modport source (output valid, output off_button_n, output red_button_n,
                    output green_button_n, input ready);
    modport sink (input valid, input off_button_n, input red_button_n,
                  input green_button_n, output ready);
endinterface

// ===== sv/irtx_result_if.sv =====
// Output channel carrying the LED level and busy flag for one tick.
interface irtx_result_if;
    logic valid;
    logic ready;
    logic ir_led;
    logic busy_res;

    modport source (output valid, output ir_led, output busy_res, input ready);
    modport sink (input valid, input ir_led, input busy_res, output ready);
endinterface

// ===== sv/irtx_cfg.sv =====
// APB register file holding the transmitter configuration.
module irtx_cfg
    import irtx_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[4:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.carrier_half_ticks <= RST_CARRIER_HALF;
            cfg_reg.cycles_per_slot    <= RST_CYCLES_SLOT;
            cfg_reg.gap_ticks          <= RST_GAP_TICKS;
            cfg_reg.addr_byte          <= RST_DEV_ADDR;
            cfg_reg.red_code           <= RST_RED_CODE;
            cfg_reg.green_code         <= RST_GREEN_CODE;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_CARRIER_HALF: cfg_reg.carrier_half_ticks <= pwdata[7:0];
                REG_CYCLES_SLOT:  cfg_reg.cycles_per_slot    <= pwdata[9:0];
                REG_GAP_TICKS:    cfg_reg.gap_ticks          <= pwdata[23:0];
                REG_DEV_ADDR:     cfg_reg.addr_byte          <= pwdata[7:0];
                REG_RED_CODE:     cfg_reg.red_code           <= pwdata[7:0];
                REG_GREEN_CODE:   cfg_reg.green_code         <= pwdata[7:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_CARRIER_HALF: prdata = {24'd0, cfg_reg.carrier_half_ticks};
            REG_CYCLES_SLOT:  prdata = {22'd0, cfg_reg.cycles_per_slot};
            REG_GAP_TICKS:    prdata = {8'd0, cfg_reg.gap_ticks};
            REG_DEV_ADDR:     prdata = {24'd0, cfg_reg.addr_byte};
            REG_RED_CODE:     prdata = {24'd0, cfg_reg.red_code};
            REG_GREEN_CODE:   prdata = {24'd0, cfg_reg.green_code};
            default:          prdata = '0;
        endcase
    end

endmodule

// ===== sv/irtx_core.sv =====
// Frame sequencer: carrier, slot and gap counters advanced once per tick.
module irtx_core
    import irtx_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    tick,
    input  logic    off_button_n,
    input  logic    red_button_n,
    input  logic    green_button_n,
    input  cfg_t    cfg,
    output result_t result,
    output phase_t  phase
);

    phase_t      phase_reg, phase_next;
    logic [5:0]  slot_reg, slot_next;
    logic [9:0]  ccc_reg, ccc_next;
    logic [7:0]  htc_reg, htc_next;
    logic        chh_reg, chh_next;
    logic [15:0] shift_reg, shift_next;
    logic [23:0] gap_reg, gap_next;

    // Effective state that the frame tick works on; a new frame starts
    // from fresh counters in the same tick.
    logic [5:0]  e_slot;
    logic [9:0]  e_ccc;
    logic [7:0]  e_htc;
    logic        e_chh;
    logic [15:0] e_shift;
    logic        run;
    logic        pressed;
    logic [7:0]  cmd;
    logic [7:0]  half_len;
    logic [9:0]  cyc_len;
    logic [7:0]  h1;
    logic [9:0]  c1;
    logic [5:0]  s1;
    logic [23:0] g1;
    slot_kind_t  kind;

    assign phase   = phase_reg;
    assign pressed = !off_button_n || !red_button_n || !green_button_n;
    assign cmd     = !off_button_n ? OFF_CODE :
                     (!red_button_n ? cfg.red_code : cfg.green_code);
    assign half_len = (cfg.carrier_half_ticks == 8'd0) ? 8'd1 : cfg.carrier_half_ticks;
    assign cyc_len  = (cfg.cycles_per_slot == 10'd0) ? 10'd1 : cfg.cycles_per_slot;
    assign h1 = e_htc + 8'd1;
    assign c1 = e_ccc + 10'd1;
    assign s1 = e_slot + 6'd1;
    assign g1 = gap_reg + 24'd1;
    assign kind = slot_kind(e_slot);

    always_comb
    begin
        phase_next = phase_reg;
        slot_next  = slot_reg;
        ccc_next   = ccc_reg;
        htc_next   = htc_reg;
        chh_next   = chh_reg;
        shift_next = shift_reg;
        gap_next   = gap_reg;
        e_slot     = slot_reg;
        e_ccc      = ccc_reg;
        e_htc      = htc_reg;
        e_chh      = chh_reg;
        e_shift    = shift_reg;
        run        = 1'b0;
        result.ir_led   = 1'b0;
        result.busy_res = 1'b1;

        case (phase_reg)
            PH_FRAME:
            begin
                run = 1'b1;
            end
            PH_GAP:
            begin
                if (g1 >= cfg.gap_ticks)
                begin
                    gap_next   = '0;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    gap_next = g1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (pressed)
                begin
                    run        = 1'b1;
                    e_slot     = '0;
                    e_ccc      = '0;
                    e_htc      = '0;
                    e_chh      = 1'b1;
                    e_shift    = {cfg.addr_byte, cmd};
                    gap_next   = '0;
                    phase_next = PH_FRAME;
                end
                else
                begin
                    result.busy_res = 1'b0;
                end
            end
        endcase

        if (run)
        begin
            slot_next  = e_slot;
            ccc_next   = e_ccc;
            chh_next   = e_chh;
            shift_next = e_shift;
            result.ir_led = ((kind == SLOT_MARK) || (kind == SLOT_BIT && e_shift[15]))
                            && e_chh;
            if (h1 >= half_len || h1 == 8'd0)
            begin
                htc_next = '0;
                if (e_chh)
                begin
                    chh_next = 1'b0;
                end
                else
                begin
                    chh_next = 1'b1;
                    if (c1 >= cyc_len || c1 == 10'd0)
                    begin
                        ccc_next = '0;
                        if (kind == SLOT_TRAIL)
                        begin
                            shift_next = {e_shift[14:0], 1'b0};
                        end
                        if (s1 >= 6'(FRAME_SLOTS))
                        begin
                            slot_next  = '0;
                            gap_next   = '0;
                            phase_next = (cfg.gap_ticks != 24'd0) ? PH_GAP : PH_IDLE;
                        end
                        else
                        begin
                            slot_next = s1;
                        end
                    end
                    else
                    begin
                        ccc_next = c1;
                    end
                end
            end
            else
            begin
                htc_next = h1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            slot_reg  <= '0;
            ccc_reg   <= '0;
            htc_reg   <= '0;
            chh_reg   <= 1'b0;
            shift_reg <= '0;
            gap_reg   <= '0;
        end
        else if (tick)
        begin
            phase_reg <= phase_next;
            slot_reg  <= slot_next;
            ccc_reg   <= ccc_next;
            htc_reg   <= htc_next;
            chh_reg   <= chh_next;
            shift_reg <= shift_next;
            gap_reg   <= gap_next;
        end
    end

endmodule

// ===== sv/irtx_out.sv =====
// Result register that decouples the output channel from tick acceptance.
module irtx_out
    import irtx_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result,
    input  logic    out_ready,
    output logic    out_valid,
    output result_t out_result,
    output logic    can_load
);

    logic    valid_reg;
    result_t result_reg;

    // The register can take a new result when empty or emptying this cycle.
    assign can_load   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

endmodule

// ===== sv/ir_remote_frame_transmitter.sv =====
// A result is valid in the cycle after its tick transaction is accepted.
// Throughput: one tick per cycle while results are taken; the sequencer
// counters and the result register each advance once per accepted tick.
// A tick is refused only while the result register holds an untaken result.
// Reset (rst_n low, asynchronous) returns the sequencer to idle, empties the
// result register and loads the register defaults.
module ir_remote_frame_transmitter
    import irtx_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    irtx_tick_if.sink             tick_in,
    irtx_result_if.source         result_out
);

    cfg_t    cfg;
    result_t core_result;
    result_t out_result;
    phase_t  phase;
    logic    can_load;
    logic    tick_accept;

    assign tick_in.ready = can_load;
    assign tick_accept   = tick_in.valid && can_load;

    irtx_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    irtx_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick           (tick_accept),
        .off_button_n   (tick_in.off_button_n),
        .red_button_n   (tick_in.red_button_n),
        .green_button_n (tick_in.green_button_n),
        .cfg            (cfg),
        .result         (core_result),
        .phase          (phase)
    );

    irtx_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (tick_accept),
        .result     (core_result),
        .out_ready  (result_out.ready),
        .out_valid  (result_out.valid),
        .out_result (out_result),
        .can_load   (can_load)
    );

    assign result_out.ir_led   = out_result.ir_led;
    assign result_out.busy_res = out_result.busy_res;

    // The emitter is never driven outside a frame.
    a_led_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid |-> (result_out.busy_res || !result_out.ir_led))
        else $error("ir_led high while not busy");

    // Every accepted tick yields a result in the next cycle.
    a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        tick_accept |=> result_out.valid)
        else $error("accepted tick produced no result");

    // An idle tick with no button down reports not busy.
    a_idle_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_accept && phase == PH_IDLE && tick_in.off_button_n
         && tick_in.red_button_n && tick_in.green_button_n)
        |=> (result_out.valid && !result_out.busy_res))
        else $error("idle tick without press reported busy");

    // A tick taken during a frame or gap always reports busy.
    a_active_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_accept && (phase == PH_FRAME || phase == PH_GAP))
        |=> result_out.busy_res)
        else $error("frame or gap tick reported not busy");

endmodule
